// ----- rtl/core/gds4_pkg.sv -----
// Shared types, constants and helper functions for the 5x5 Gaussian
// decimate-by-four block. No dependencies.
package gds4_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOTS     = 4;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int WIN       = 5;
    localparam int WIN_W     = $clog2(WIN);
    localparam int PIX_W     = 16;
    localparam int WIDTH_W   = 13;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_W     = 16;
    localparam int OCOL_W    = 10;
    localparam int OROW_W    = 14;
    localparam int COLSUM_W  = 22;
    localparam int SUM_W     = 24;
    localparam int SHIFT     = 8;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd4096;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN_W-1:0] t_tap_dist;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // weight[vertical tap][horizontal tap]
    localparam logic [3:0] WEIGHT [WIN][WIN] = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    // Distance back from pos to tap t of the window centred on the stride
    // point below pos, with edge replication and limited to four.
    function automatic t_tap_dist tap_back(input logic [15:0] pos,
                                           input logic [2:0]  t,
                                           input logic [16:0] limit);
        logic signed [18:0] j;
        logic signed [18:0] top;
        logic [16:0]        d;
        j   = $signed({3'b000, pos[15:2], 2'b00}) - 19'sd2 + $signed({16'd0, t});
        top = $signed({2'b00, limit}) - 19'sd1;
        if (j < 19'sd0) begin
            j = 19'sd0;
        end
        if (j > top) begin
            j = top;
        end
        if (j > $signed({3'b000, pos})) begin
            j = $signed({3'b000, pos});
        end
        d = {1'b0, pos} - j[16:0];
        return (d > 17'd4) ? t_tap_dist'(3'd4) : t_tap_dist'(d[2:0]);
    endfunction

    // True where pos completes a window along one axis.
    function automatic logic is_emit(input logic [15:0] pos, input logic [16:0] limit);
        logic [16:0] last;
        last = limit - 17'd1;
        return (pos[1:0] == 2'd2) || (({1'b0, pos} == last) && (pos[1:0] < 2'd2));
    endfunction

endpackage

// ----- rtl/core/gaussian_downsample_by_four.sv -----
// 5x5 Gaussian filter and decimate by four over a raster pixel stream.
// Depends on gds4_pkg; the four row buffers share one memory, one column per word.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_pixel_value
//  output  | out       | o_out_valid / i_out_stall | o_filtered_value, o_out_col,
//          |           |                           | o_out_row, o_frame_last
//  config  | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One pixel is taken every cycle while o_in_stall is low; o_out_valid rises once the pixel
// that completes a window has passed the stages: row buffer read, window shift, column sums,
// final sum. The whole pipeline advances together; it halts only while the output
// register holds a result that is stalled, and o_in_stall follows that condition.
// Reset is synchronous: it clears the stage valids and position counters and loads the
// configuration registers with their reset values. A configuration write restarts the frame at the next pixel.
module gaussian_downsample_by_four (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pixel_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_filtered_value,
    output logic [9:0]  o_out_col,
    output logic [13:0] o_out_row,
    output logic        o_frame_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration and position
    logic [gds4_pkg::WIDTH_W-1:0]  r_width;
    logic [gds4_pkg::HEIGHT_W-1:0] r_height;
    logic [gds4_pkg::WIDTH_W-1:0]  w_eff;
    logic [gds4_pkg::HEIGHT_W-1:0] h_eff;
    logic [gds4_pkg::WIDTH_W-1:0]  w_m1;
    logic [gds4_pkg::HEIGHT_W-1:0] h_m1;
    logic [16:0]                   limit_w;
    logic [16:0]                   limit_h;
    logic [gds4_pkg::COL_W-1:0]    r_col;
    logic [gds4_pkg::COL_W-1:0]    n_col;
    logic [gds4_pkg::HEIGHT_W-1:0] r_row;
    logic [gds4_pkg::HEIGHT_W-1:0] n_row;
    logic                          adv;
    logic                          accept;

    // row buffers: one word per column, slot s in bits s*PIX_W upwards
    logic [gds4_pkg::SLOTS*gds4_pkg::PIX_W-1:0] r_mem [gds4_pkg::MAX_WIDTH];
    gds4_pkg::t_pix r_rd  [gds4_pkg::SLOTS];

    // stage 1
    logic                            r_v1;
    gds4_pkg::t_pix                  r_pix1;
    logic [gds4_pkg::SLOT_W-1:0]     r_rlo1;
    gds4_pkg::t_tap_dist             r_dv1 [gds4_pkg::WIN];
    gds4_pkg::t_tap_dist             r_dh1 [gds4_pkg::WIN];
    logic                            r_emit1;
    logic [gds4_pkg::OCOL_W-1:0]     r_ox1;
    logic [gds4_pkg::OROW_W-1:0]     r_oy1;
    logic                            r_last1;
    gds4_pkg::t_pix                  col_new [gds4_pkg::WIN];

    // window: [column distance back][vertical tap]
    gds4_pkg::t_pix                  r_win [gds4_pkg::WIN][gds4_pkg::WIN];

    // stage 2
    logic                            r_v2;
    gds4_pkg::t_tap_dist             r_dh2 [gds4_pkg::WIN];
    logic [gds4_pkg::OCOL_W-1:0]     r_ox2;
    logic [gds4_pkg::OROW_W-1:0]     r_oy2;
    logic                            r_last2;
    logic [gds4_pkg::COLSUM_W-1:0]   colsum [gds4_pkg::WIN];

    // stage 3
    logic                            r_v3;
    logic [gds4_pkg::COLSUM_W-1:0]   r_colsum3 [gds4_pkg::WIN];
    logic [gds4_pkg::OCOL_W-1:0]     r_ox3;
    logic [gds4_pkg::OROW_W-1:0]     r_oy3;
    logic                            r_last3;
    logic [gds4_pkg::SUM_W-1:0]      total;

    // output register
    logic                            r_out_valid;
    logic [15:0]                     r_filtered;
    logic [gds4_pkg::OCOL_W-1:0]     r_out_col;
    logic [gds4_pkg::OROW_W-1:0]     r_out_row;
    logic                            r_frame_last;

    assign w_eff = (r_width == '0) ? gds4_pkg::WIDTH_W'(1)
                 : (r_width > gds4_pkg::WIDTH_RESET) ? gds4_pkg::WIDTH_RESET : r_width;
    assign h_eff   = (r_height == '0) ? gds4_pkg::HEIGHT_W'(1) : r_height;
    assign w_m1    = w_eff - gds4_pkg::WIDTH_W'(1);
    assign h_m1    = h_eff - gds4_pkg::HEIGHT_W'(1);
    assign limit_w = {4'b0000, w_eff};
    assign limit_h = {1'b0, h_eff};

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept     = i_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gds4_pkg::WIDTH_RESET;
            r_height <= gds4_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (gds4_pkg::t_cfg_index'(i_cfg_index))
                gds4_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[gds4_pkg::WIDTH_W-1:0];
                gds4_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next pixel position; a register write restarts the frame
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (({1'b0, r_col} + gds4_pkg::WIDTH_W'(1)) >= w_eff) begin
                n_col = '0;
                if (({1'b0, r_row} + 17'd1) >= limit_h) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + gds4_pkg::HEIGHT_W'(1);
                end
            end else begin
                n_col = r_col + gds4_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // row buffers: read the word of this column, write the new pixel into its slot
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < gds4_pkg::SLOTS; s++) begin
            if (adv) begin
                r_rd[s] <= r_mem[r_col][s*gds4_pkg::PIX_W +: gds4_pkg::PIX_W];
            end
            if (accept && (r_row[gds4_pkg::SLOT_W-1:0] == gds4_pkg::SLOT_W'(s))) begin
                r_mem[r_col][s*gds4_pkg::PIX_W +: gds4_pkg::PIX_W] <= i_pixel_value;
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pix1  <= i_pixel_value;
            r_rlo1  <= r_row[gds4_pkg::SLOT_W-1:0];
            for (int t = 0; t < gds4_pkg::WIN; t++) begin
                r_dv1[t] <= gds4_pkg::tap_back(r_row, 3'(t), limit_h);
                r_dh1[t] <= gds4_pkg::tap_back({4'b0000, r_col}, 3'(t), limit_w);
            end
            r_emit1 <= gds4_pkg::is_emit(r_row, limit_h)
                    && gds4_pkg::is_emit({4'b0000, r_col}, limit_w);
            r_ox1   <= r_col[gds4_pkg::COL_W-1:2];
            r_oy1   <= r_row[gds4_pkg::HEIGHT_W-1:2];
            r_last1 <= (r_col[gds4_pkg::COL_W-1:2] == w_m1[gds4_pkg::COL_W-1:2])
                    && (r_row[gds4_pkg::HEIGHT_W-1:2] == h_m1[gds4_pkg::HEIGHT_W-1:2]);
        end
    end

    // vertical taps of the new column; distance zero is the pixel itself
    always_comb begin
        for (int t = 0; t < gds4_pkg::WIN; t++) begin
            if (r_dv1[t] == '0) begin
                col_new[t] = r_pix1;
            end else begin
                col_new[t] = r_rd[r_rlo1 - r_dv1[t][gds4_pkg::SLOT_W-1:0]];
            end
        end
    end

    // shift the window by one column on each real pixel
    always_ff @(posedge i_clk) begin
        if (adv && r_v1) begin
            r_win[0] <= col_new;
            for (int k = 1; k < gds4_pkg::WIN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1 && r_emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dh2   <= r_dh1;
            r_ox2   <= r_ox1;
            r_oy2   <= r_oy1;
            r_last2 <= r_last1;
        end
    end

    // weighted vertical sum of each selected window column
    always_comb begin
        gds4_pkg::t_pix sel [gds4_pkg::WIN];
        logic [gds4_pkg::COLSUM_W-1:0] acc;
        for (int k = 0; k < gds4_pkg::WIN; k++) begin
            sel = r_win[r_dh2[k]];
            acc = '0;
            for (int t = 0; t < gds4_pkg::WIN; t++) begin
                acc = acc + gds4_pkg::COLSUM_W'(gds4_pkg::WEIGHT[t][k])
                          * gds4_pkg::COLSUM_W'(sel[t]);
            end
            colsum[k] = acc;
        end
    end

    // stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_colsum3 <= colsum;
            r_ox3     <= r_ox2;
            r_oy3     <= r_oy2;
            r_last3   <= r_last2;
        end
    end

    always_comb begin
        total = '0;
        for (int k = 0; k < gds4_pkg::WIN; k++) begin
            total = total + gds4_pkg::SUM_W'(r_colsum3[k]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_filtered   <= total[gds4_pkg::SHIFT +: 16];
            r_out_col    <= r_ox3;
            r_out_row    <= r_oy3;
            r_frame_last <= r_last3;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_filtered;
    assign o_out_col        = r_out_col;
    assign o_out_row        = r_out_row;
    assign o_frame_last     = r_frame_last;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < w_eff))
        else $error("column counter beyond frame width");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0 && r_row == '0))
        else $error("register write did not restart the frame");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we && ({1'b0, r_col} == w_m1) && (r_row == h_m1))
        |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the last pixel of the frame");

endmodule
